// ===== src/assert_macros.svh =====
// Assertion macros shared by the plane projection extent tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check: when the antecedent holds, the consequent holds too.
`define PPET_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle check: when the antecedent holds, the consequent holds in the next cycle.
`define PPET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/ppet_pkg.sv =====
// Shared widths, types and helper functions of the plane projection extent tracker.
package ppet_pkg;

    // Point coordinates, packed unit vectors and derived arithmetic widths.
    localparam int COORD_W   = 32;
    localparam int SLOT_W    = 21;
    localparam int NORM_FRAC = 19;
    localparam int VEC_W     = 3 * SLOT_W;
    localparam int PROD_W    = COORD_W + SLOT_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int S_W       = DOT_W - NORM_FRAC + 1;
    localparam int SN_W      = S_W + SLOT_W;
    localparam int Q_W       = SN_W - NORM_FRAC + 1;
    localparam int QB_W      = Q_W + SLOT_W;
    localparam int QDOT_W    = QB_W + 2;
    localparam int K_W       = COORD_W + 2;
    localparam int KN_W      = K_W + SLOT_W;
    localparam int THICK_W   = COORD_W + 1;
    localparam int WIDE_W    = QDOT_W;
    localparam int CFG_IDX_W = 2;

    // Queue depths (powers of two) and their pointer and count widths.
    localparam int MID_DEPTH = 4;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Saturation limits, held at the widest internal width.
    localparam logic signed [WIDE_W-1:0] COORD_MAX =
        (WIDE_W'(1) << (COORD_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] COORD_MIN = ~COORD_MAX;
    localparam logic signed [WIDE_W-1:0] KEPT_MAX =
        (WIDE_W'(1) << (K_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] KEPT_MIN = ~KEPT_MAX;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SLOT_W-1:0]  t_slot;
    typedef logic [VEC_W-1:0]          t_vec;
    typedef logic signed [K_W-1:0]     t_kept;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_UNIT,
        CFG_PLANE_OFFSET,
        CFG_BASIS_FIRST,
        CFG_BASIS_SECOND
    } t_cfg_idx;

    typedef struct packed {
        t_vec   normal;
        t_coord offset;
        t_vec   basis1;
        t_vec   basis2;
    } t_cfg;

    // One accepted point; element 0 is x.
    typedef struct packed {
        t_coord [2:0] p;
        logic         last;
    } t_point;

    // Classified point passed from the front to the back.
    typedef struct packed {
        t_coord [2:0]           p;
        logic signed [S_W-1:0]  s;
        logic                   below;
        logic [COORD_W-1:0]     mag;
        t_kept                  ks;
        logic                   last;
    } t_mid;

    typedef struct packed {
        t_coord             u;
        t_coord             v;
        logic               last;
        t_coord             ox;
        t_coord             oy;
        t_coord             oz;
        logic [THICK_W-1:0] thick;
    } t_result;

    // Component i of a packed vector.
    function automatic t_slot vec_slot(input t_vec v, input int i);
        return v[i*SLOT_W +: SLOT_W];
    endfunction

    // Saturate a wide signed value to a coordinate.
    function automatic t_coord sat_coord(input logic signed [WIDE_W-1:0] x);
        if (x > COORD_MAX) begin
            return COORD_MAX[COORD_W-1:0];
        end else if (x < COORD_MIN) begin
            return COORD_MIN[COORD_W-1:0];
        end
        return x[COORD_W-1:0];
    endfunction

    // Saturate a wide signed value to the kept distance width.
    function automatic t_kept sat_kept(input logic signed [WIDE_W-1:0] x);
        if (x > KEPT_MAX) begin
            return KEPT_MAX[K_W-1:0];
        end else if (x < KEPT_MIN) begin
            return KEPT_MIN[K_W-1:0];
        end
        return x[K_W-1:0];
    endfunction

endpackage

// ===== src/ppet_front.sv =====
// Front part: takes points, computes the signed plane distance and classifies it.
module ppet_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ppet_pkg::t_cfg                       i_cfg,
    input  logic                                 i_push,
    input  ppet_pkg::t_point                     i_point,
    input  logic [ppet_pkg::MID_CNT_W-1:0]       i_mid_count,
    output logic                                 o_ready,
    output logic                                 o_mid_we,
    output ppet_pkg::t_mid                       o_mid_data
);

    logic                                     r_v1;
    logic signed [ppet_pkg::PROD_W-1:0]       r_prod [3];
    ppet_pkg::t_coord                         r_p1 [3];
    logic                                     r_last1;

    logic                                     r_v2;
    logic signed [ppet_pkg::S_W-1:0]          r_s;
    ppet_pkg::t_coord                         r_p2 [3];
    logic                                     r_last2;

    logic [ppet_pkg::MID_CNT_W:0]             used;
    logic signed [ppet_pkg::DOT_W-1:0]        dot_sum;
    logic signed [ppet_pkg::DOT_W-1:0]        dot_fl;
    logic signed [ppet_pkg::S_W-1:0]          n_s;
    logic signed [ppet_pkg::S_W:0]            s_ext;
    logic [ppet_pkg::S_W:0]                   s_abs;

    // Accept only when the queue has room for every point still in flight here.
    always_comb begin
        used = (ppet_pkg::MID_CNT_W+1)'(i_mid_count)
             + (ppet_pkg::MID_CNT_W+1)'(r_v1)
             + (ppet_pkg::MID_CNT_W+1)'(r_v2);
        o_ready = used < (ppet_pkg::MID_CNT_W+1)'(ppet_pkg::MID_DEPTH);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
        end
    end

    // Stage one: the three products of the point with the normal.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= ppet_pkg::PROD_W'($signed(i_point.p[i]))
                           * ppet_pkg::PROD_W'(ppet_pkg::vec_slot(i_cfg.normal, i));
                r_p1[i]   <= i_point.p[i];
            end
            r_last1 <= i_point.last;
        end
    end

    // Stage two: exact sum, floor to Q16.16 and add the plane constant.
    always_comb begin
        dot_sum = ppet_pkg::DOT_W'(r_prod[0]) + ppet_pkg::DOT_W'(r_prod[1])
                + ppet_pkg::DOT_W'(r_prod[2]);
        dot_fl  = dot_sum >>> ppet_pkg::NORM_FRAC;
        n_s     = ppet_pkg::S_W'(dot_fl) + ppet_pkg::S_W'($signed(i_cfg.offset));
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_s     <= n_s;
            r_p2    <= r_p1;
            r_last2 <= r_last1;
        end
    end

    // Classification: side, saturated magnitude and saturated signed distance.
    always_comb begin
        s_ext = (ppet_pkg::S_W+1)'(r_s);
        s_abs = r_s[ppet_pkg::S_W-1] ? -s_ext : s_ext;
        for (int i = 0; i < 3; i++) begin
            o_mid_data.p[i] = r_p2[i];
        end
        o_mid_data.s     = r_s;
        o_mid_data.below = r_s[ppet_pkg::S_W-1];
        if (|s_abs[ppet_pkg::S_W:ppet_pkg::COORD_W]) begin
            o_mid_data.mag = '1;
        end else begin
            o_mid_data.mag = s_abs[ppet_pkg::COORD_W-1:0];
        end
        o_mid_data.ks   = ppet_pkg::sat_kept(ppet_pkg::WIDE_W'(r_s));
        o_mid_data.last = r_last2;
        o_mid_we        = r_v2;
    end

endmodule

// ===== src/ppet_queue.sv =====
// Short queue of classified points between the front and the back.
`include "assert_macros.svh"

module ppet_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  ppet_pkg::t_mid                   i_wdata,
    input  logic                             i_re,
    output ppet_pkg::t_mid                   o_rdata,
    output logic [ppet_pkg::MID_CNT_W-1:0]   o_count
);

    ppet_pkg::t_mid                       r_mem [ppet_pkg::MID_DEPTH];
    logic [ppet_pkg::MID_PTR_W-1:0]       r_wp;
    logic [ppet_pkg::MID_PTR_W-1:0]       r_rp;
    logic [ppet_pkg::MID_CNT_W-1:0]       r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_we) begin
                r_wp <= r_wp + ppet_pkg::MID_PTR_W'(1);
            end
            if (i_re) begin
                r_rp <= r_rp + ppet_pkg::MID_PTR_W'(1);
            end
            r_count <= r_count + ppet_pkg::MID_CNT_W'(i_we) - ppet_pkg::MID_CNT_W'(i_re);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_count = r_count;

    `PPET_ASSERT_SAME(a_mid_no_overflow, i_clk, i_rst_n, i_we,
        r_count < ppet_pkg::MID_CNT_W'(ppet_pkg::MID_DEPTH) || i_re)
    `PPET_ASSERT_SAME(a_mid_no_underflow, i_clk, i_rst_n, i_re, r_count != '0)
    `PPET_ASSERT_NEXT(a_mid_count_drop, i_clk, i_rst_n, i_re && !i_we,
        r_count == $past(r_count) - ppet_pkg::MID_CNT_W'(1))

endmodule

// ===== src/ppet_back.sv =====
// Back part: extent tracking, projection onto the plane basis and the result queue.
`include "assert_macros.svh"

module ppet_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ppet_pkg::t_cfg                   i_cfg,
    input  ppet_pkg::t_mid                   i_mid_head,
    input  logic [ppet_pkg::MID_CNT_W-1:0]   i_mid_count,
    output logic                             o_mid_pop,
    input  logic                             i_out_pop,
    output logic                             o_out_empty,
    output ppet_pkg::t_result                o_result
);

    // Set state.
    logic                                 r_seen_below;
    logic                                 r_seen_above;
    logic [ppet_pkg::COORD_W-1:0]         r_near_above;
    logic [ppet_pkg::COORD_W-1:0]         r_far_below;
    logic [ppet_pkg::COORD_W-1:0]         r_far_above;
    ppet_pkg::t_kept                      r_kept;

    logic                                 n_seen_below;
    logic                                 n_seen_above;
    logic [ppet_pkg::COORD_W-1:0]         n_near_above;
    logic [ppet_pkg::COORD_W-1:0]         n_far_below;
    logic [ppet_pkg::COORD_W-1:0]         n_far_above;
    ppet_pkg::t_kept                      n_kept;
    logic [ppet_pkg::THICK_W-1:0]         thick;

    // Pipeline stages.
    logic                                 r_v1;
    logic signed [ppet_pkg::SN_W-1:0]     r_sn [3];
    ppet_pkg::t_coord                     r_bp [3];
    logic                                 r_last1;
    ppet_pkg::t_kept                      r_kept1;
    logic [ppet_pkg::THICK_W-1:0]         r_thick1;

    logic                                 r_v2;
    logic signed [ppet_pkg::Q_W-1:0]      r_q [3];
    logic signed [ppet_pkg::KN_W-1:0]     r_kn [3];
    logic                                 r_last2;
    logic [ppet_pkg::THICK_W-1:0]         r_thick2;

    logic                                 r_v3;
    logic signed [ppet_pkg::QB_W-1:0]     r_qb1 [3];
    logic signed [ppet_pkg::QB_W-1:0]     r_qb2 [3];
    ppet_pkg::t_coord                     r_off [3];
    logic                                 r_last3;
    logic [ppet_pkg::THICK_W-1:0]         r_thick3;

    // Result queue.
    ppet_pkg::t_result                    r_omem [ppet_pkg::OUT_DEPTH];
    logic [ppet_pkg::OUT_PTR_W-1:0]       r_owp;
    logic [ppet_pkg::OUT_PTR_W-1:0]       r_orp;
    logic [ppet_pkg::OUT_CNT_W-1:0]       r_ocnt;

    logic [ppet_pkg::OUT_CNT_W:0]         used;
    logic                                 out_pop;
    logic signed [ppet_pkg::QDOT_W-1:0]   qsum1;
    logic signed [ppet_pkg::QDOT_W-1:0]   qsum2;
    ppet_pkg::t_result                    res;

    // Take a point only when the result queue has room for all in flight here.
    always_comb begin
        used = (ppet_pkg::OUT_CNT_W+1)'(r_ocnt)
             + (ppet_pkg::OUT_CNT_W+1)'(r_v1)
             + (ppet_pkg::OUT_CNT_W+1)'(r_v2)
             + (ppet_pkg::OUT_CNT_W+1)'(r_v3);
        o_mid_pop = (i_mid_count != '0)
                 && (used < (ppet_pkg::OUT_CNT_W+1)'(ppet_pkg::OUT_DEPTH));
        out_pop   = i_out_pop && (r_ocnt != '0);
    end

    // Extent update for the point at the head of the queue.
    always_comb begin
        n_seen_below = r_seen_below;
        n_seen_above = r_seen_above;
        n_near_above = r_near_above;
        n_far_below  = r_far_below;
        n_far_above  = r_far_above;
        n_kept       = r_kept;
        if (i_mid_head.below) begin
            n_seen_below = 1'b1;
            if (i_mid_head.mag > r_far_below) begin
                n_far_below = i_mid_head.mag;
                n_kept      = i_mid_head.ks;
            end
        end else begin
            // Nearest point above counts only while nothing below has been seen.
            if (!r_seen_below && (!r_seen_above || i_mid_head.mag < r_near_above)) begin
                n_near_above = i_mid_head.mag;
                n_kept       = i_mid_head.ks;
            end
            n_seen_above = 1'b1;
            if (i_mid_head.mag > r_far_above) begin
                n_far_above = i_mid_head.mag;
            end
        end
        thick = ppet_pkg::THICK_W'(n_far_below) + ppet_pkg::THICK_W'(n_far_above);
    end

    // Set state registers; the last point of a set clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_below <= 1'b0;
            r_seen_above <= 1'b0;
            r_near_above <= '1;
            r_far_below  <= '0;
            r_far_above  <= '0;
            r_kept       <= '0;
        end else if (o_mid_pop) begin
            if (i_mid_head.last) begin
                r_seen_below <= 1'b0;
                r_seen_above <= 1'b0;
                r_near_above <= '1;
                r_far_below  <= '0;
                r_far_above  <= '0;
                r_kept       <= '0;
            end else begin
                r_seen_below <= n_seen_below;
                r_seen_above <= n_seen_above;
                r_near_above <= n_near_above;
                r_far_below  <= n_far_below;
                r_far_above  <= n_far_above;
                r_kept       <= n_kept;
            end
        end
    end

    // Stage valid bits and result queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            r_v1 <= o_mid_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_owp <= r_owp + ppet_pkg::OUT_PTR_W'(1);
            end
            if (out_pop) begin
                r_orp <= r_orp + ppet_pkg::OUT_PTR_W'(1);
            end
            r_ocnt <= r_ocnt + ppet_pkg::OUT_CNT_W'(r_v3) - ppet_pkg::OUT_CNT_W'(out_pop);
        end
    end

    // Stage one: distance times normal, plus the set summary after this point.
    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            for (int i = 0; i < 3; i++) begin
                r_sn[i] <= ppet_pkg::SN_W'($signed(i_mid_head.s))
                         * ppet_pkg::SN_W'(ppet_pkg::vec_slot(i_cfg.normal, i));
                r_bp[i] <= i_mid_head.p[i];
            end
            r_last1  <= i_mid_head.last;
            r_kept1  <= n_kept;
            r_thick1 <= thick;
        end
    end

    // Stage two: projected point and kept distance times normal.
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int i = 0; i < 3; i++) begin
                r_q[i]  <= ppet_pkg::Q_W'($signed(r_bp[i]))
                         - ppet_pkg::Q_W'(r_sn[i] >>> ppet_pkg::NORM_FRAC);
                r_kn[i] <= ppet_pkg::KN_W'(r_kept1)
                         * ppet_pkg::KN_W'(ppet_pkg::vec_slot(i_cfg.normal, i));
            end
            r_last2  <= r_last1;
            r_thick2 <= r_thick1;
        end
    end

    // Stage three: products with both basis vectors; offset vector floored and saturated.
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            for (int i = 0; i < 3; i++) begin
                r_qb1[i] <= ppet_pkg::QB_W'(r_q[i])
                          * ppet_pkg::QB_W'(ppet_pkg::vec_slot(i_cfg.basis1, i));
                r_qb2[i] <= ppet_pkg::QB_W'(r_q[i])
                          * ppet_pkg::QB_W'(ppet_pkg::vec_slot(i_cfg.basis2, i));
                r_off[i] <= r_last2
                          ? ppet_pkg::sat_coord(
                                ppet_pkg::WIDE_W'(r_kn[i] >>> ppet_pkg::NORM_FRAC))
                          : '0;
            end
            r_last3  <= r_last2;
            r_thick3 <= r_last2 ? r_thick2 : '0;
        end
    end

    // Final sums into the result queue.
    always_comb begin
        qsum1 = ppet_pkg::QDOT_W'(r_qb1[0]) + ppet_pkg::QDOT_W'(r_qb1[1])
              + ppet_pkg::QDOT_W'(r_qb1[2]);
        qsum2 = ppet_pkg::QDOT_W'(r_qb2[0]) + ppet_pkg::QDOT_W'(r_qb2[1])
              + ppet_pkg::QDOT_W'(r_qb2[2]);
        res.u     = ppet_pkg::sat_coord(ppet_pkg::WIDE_W'(qsum1 >>> ppet_pkg::NORM_FRAC));
        res.v     = ppet_pkg::sat_coord(ppet_pkg::WIDE_W'(qsum2 >>> ppet_pkg::NORM_FRAC));
        res.last  = r_last3;
        res.ox    = r_off[0];
        res.oy    = r_off[1];
        res.oz    = r_off[2];
        res.thick = r_thick3;
    end

    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_omem[r_owp] <= res;
        end
    end

    assign o_result    = r_omem[r_orp];
    assign o_out_empty = (r_ocnt == '0);

    `PPET_ASSERT_SAME(a_out_no_overflow, i_clk, i_rst_n, r_v3,
        r_ocnt < ppet_pkg::OUT_CNT_W'(ppet_pkg::OUT_DEPTH))
    `PPET_ASSERT_SAME(a_kept_nonneg_above, i_clk, i_rst_n, !r_seen_below,
        !r_kept[ppet_pkg::K_W-1])
    `PPET_ASSERT_SAME(a_summary_only_last, i_clk, i_rst_n, r_v3 && !r_last3,
        r_thick3 == '0)

endmodule

// ===== src/plane_projection_extent_tracker.sv =====
// Top level of the plane projection extent tracker: configuration registers and wiring.
//
// Use: write the normal, plane constant and two basis vectors on the configuration port
// while the block is idle, then push points (Q16.16) through the input queue interface
// (push/full). Each point yields one result on the output queue interface (empty/pop):
// its coordinates along the two basis vectors, and, on the point marked last, the offset
// vector of the kept distance and the set thickness, after which the set state clears.
// A result is visible (empty low) once its point has passed the front, the middle
// queue and the back. Throughput: one point per cycle while full is low; the front
// computes the distance in two stages, the back tracks extents and projects in three
// stages, and a four-entry queue sits between them. The result queue holds eight beats;
// when the receiver stops popping it fills, the back stops taking points, the middle
// queue fills and full rises. Reset is synchronous: configuration returns to zero,
// both queues empty and the set state clears; no clearing pass follows.
module plane_projection_extent_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [ppet_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [ppet_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [ppet_pkg::COORD_W-1:0] i_point_z,
    input  logic                                i_point_last,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [ppet_pkg::COORD_W-1:0] o_plane_u,
    output logic signed [ppet_pkg::COORD_W-1:0] o_plane_v,
    output logic                                o_set_done,
    output logic signed [ppet_pkg::COORD_W-1:0] o_offset_x,
    output logic signed [ppet_pkg::COORD_W-1:0] o_offset_y,
    output logic signed [ppet_pkg::COORD_W-1:0] o_offset_z,
    output logic [ppet_pkg::THICK_W-1:0]        o_thickness,
    input  logic                                i_cfg_we,
    input  logic [ppet_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppet_pkg::VEC_W-1:0]          i_cfg_data
);

    ppet_pkg::t_cfg                       r_cfg;
    ppet_pkg::t_point                     point;
    ppet_pkg::t_mid                       mid_wdata;
    ppet_pkg::t_mid                       mid_head;
    ppet_pkg::t_result                    result;
    logic [ppet_pkg::MID_CNT_W-1:0]       mid_count;
    logic                                 front_ready;
    logic                                 in_beat;
    logic                                 mid_we;
    logic                                 mid_pop;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (ppet_pkg::t_cfg_idx'(i_cfg_idx))
                ppet_pkg::CFG_NORMAL_UNIT:  r_cfg.normal <= i_cfg_data;
                ppet_pkg::CFG_PLANE_OFFSET: r_cfg.offset <= i_cfg_data[ppet_pkg::COORD_W-1:0];
                ppet_pkg::CFG_BASIS_FIRST:  r_cfg.basis1 <= i_cfg_data;
                ppet_pkg::CFG_BASIS_SECOND: r_cfg.basis2 <= i_cfg_data;
            endcase
        end
    end

    // Input beat.
    always_comb begin
        full         = !front_ready;
        in_beat      = push && front_ready;
        point.p[0]   = i_point_x;
        point.p[1]   = i_point_y;
        point.p[2]   = i_point_z;
        point.last   = i_point_last;
    end

    ppet_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (in_beat),
        .i_point     (point),
        .i_mid_count (mid_count),
        .o_ready     (front_ready),
        .o_mid_we    (mid_we),
        .o_mid_data  (mid_wdata)
    );

    ppet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mid_we),
        .i_wdata (mid_wdata),
        .i_re    (mid_pop),
        .o_rdata (mid_head),
        .o_count (mid_count)
    );

    ppet_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid_head  (mid_head),
        .i_mid_count (mid_count),
        .o_mid_pop   (mid_pop),
        .i_out_pop   (pop),
        .o_out_empty (empty),
        .o_result    (result)
    );

    // Result fields.
    assign o_plane_u   = result.u;
    assign o_plane_v   = result.v;
    assign o_set_done  = result.last;
    assign o_offset_x  = result.ox;
    assign o_offset_y  = result.oy;
    assign o_offset_z  = result.oz;
    assign o_thickness = result.thick;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the plane projection extent tracker with its own projection model.
module tb_top;
    import ppet_pkg::*;

    typedef logic signed [127:0] t_wide;
    typedef t_wide t_triple [3];
    typedef enum int {DRAIN_ALWAYS, DRAIN_HALF, DRAIN_MOSTLY, DRAIN_PATTERN} t_drain;

    localparam t_wide  COORD_HI     = 64'sd2147483647;
    localparam t_wide  COORD_LO     = -64'sd2147483648;
    localparam t_wide  KEPT_HI      = 64'sd8589934591;
    localparam t_wide  KEPT_LO      = -64'sd8589934592;
    localparam t_wide  MAG_CAP      = 64'sd4294967295;
    localparam t_slot  SLOT_ONE     = 21'sd524288;
    localparam t_slot  SLOT_HI      = 21'sd1048575;
    localparam t_slot  SLOT_LO      = 21'h10_0000;
    localparam t_coord ONE_Q16      = 32'sh0001_0000;
    localparam t_coord COORD_TOP    = 32'sh7fff_ffff;
    localparam t_coord COORD_BOTTOM = 32'h8000_0000;
    localparam int     STALL_LIMIT  = 4000;

    // Block ports; every input starts at a known value.
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               push         = 1'b0;
    logic               full;
    t_coord             i_point_x    = '0;
    t_coord             i_point_y    = '0;
    t_coord             i_point_z    = '0;
    logic               i_point_last = 1'b0;
    logic               empty;
    logic               pop          = 1'b0;
    t_coord             o_plane_u;
    t_coord             o_plane_v;
    logic               o_set_done;
    t_coord             o_offset_x;
    t_coord             o_offset_y;
    t_coord             o_offset_z;
    logic [THICK_W-1:0] o_thickness;
    logic               i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [VEC_W-1:0]   i_cfg_data   = '0;

    // Plane setup and per-set extent state as the testbench sees them.
    t_vec   plane_normal = '0;
    t_coord plane_const  = '0;
    t_vec   basis_u      = '0;
    t_vec   basis_v      = '0;
    logic   any_below    = 1'b0;
    logic   any_above    = 1'b0;
    t_wide  nearest_up   = MAG_CAP;
    t_wide  deepest_down = '0;
    t_wide  highest_up   = '0;
    t_wide  kept_dist    = '0;

    t_result pending_results[$];
    int      mismatches    = 0;
    int      burst_left    = 0;
    bit      gaps_on       = 1'b1;
    int      hold_request  = 0;
    int      hold_left     = 0;
    int      drain_tick    = 0;
    t_drain  drain_mode    = DRAIN_ALWAYS;
    int      quiet_cycles  = 0;

    plane_projection_extent_tracker u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Component idx of a packed vector, sign-extended.
    function automatic t_wide slot_of(input t_vec vec, input int idx);
        t_slot c;
        c = vec[idx*SLOT_W +: SLOT_W];
        return c;
    endfunction

    function automatic t_wide floor_q19(input t_wide x);
        return x >>> NORM_FRAC;
    endfunction

    function automatic t_wide clamp(input t_wide x, input t_wide lo, input t_wide hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // Exact dot product with a Q1.19 vector, floored back to Q16.16.
    function automatic t_wide dot3(input t_triple a, input t_vec vec);
        return floor_q19(a[0] * slot_of(vec, 0) + a[1] * slot_of(vec, 1)
                         + a[2] * slot_of(vec, 2));
    endfunction

    // Projects one point, updates the set extents and returns the expected beat.
    function automatic t_result project_point(input t_point pt);
        t_triple pw;
        t_triple q;
        t_coord  c;
        t_wide   sdist;
        t_wide   mag;
        t_wide   ks;
        t_wide   total;
        t_result r;
        int      i;
        for (i = 0; i < 3; i++) begin
            c = pt.p[i];
            pw[i] = c;
        end
        sdist = dot3(pw, plane_normal) + plane_const;
        ks = clamp(sdist, KEPT_LO, KEPT_HI);
        mag = sdist < 0 ? -sdist : sdist;
        if (mag > MAG_CAP) begin
            mag = MAG_CAP;
        end
        for (i = 0; i < 3; i++) begin
            q[i] = pw[i] - floor_q19(sdist * slot_of(plane_normal, i));
        end
        r.u = t_coord'(clamp(dot3(q, basis_u), COORD_LO, COORD_HI));
        r.v = t_coord'(clamp(dot3(q, basis_v), COORD_LO, COORD_HI));

        // Below the plane the farthest point wins; above it only the nearest counts,
        // and only until a point below shows up.
        if (sdist < 0) begin
            any_below = 1'b1;
            if (mag > deepest_down) begin
                deepest_down = mag;
                kept_dist = ks;
            end
        end else begin
            if (!any_below && (!any_above || mag < nearest_up)) begin
                nearest_up = mag;
                kept_dist = ks;
            end
            any_above = 1'b1;
            if (mag > highest_up) begin
                highest_up = mag;
            end
        end

        r.last  = pt.last;
        r.ox    = '0;
        r.oy    = '0;
        r.oz    = '0;
        r.thick = '0;
        if (pt.last) begin
            r.ox = t_coord'(clamp(floor_q19(kept_dist * slot_of(plane_normal, 0)),
                                  COORD_LO, COORD_HI));
            r.oy = t_coord'(clamp(floor_q19(kept_dist * slot_of(plane_normal, 1)),
                                  COORD_LO, COORD_HI));
            r.oz = t_coord'(clamp(floor_q19(kept_dist * slot_of(plane_normal, 2)),
                                  COORD_LO, COORD_HI));
            total = deepest_down + highest_up;
            r.thick = total[THICK_W-1:0];
            any_below = 1'b0;
            any_above = 1'b0;
            nearest_up = MAG_CAP;
            deepest_down = '0;
            highest_up = '0;
            kept_dist = '0;
        end
        return r;
    endfunction

    function automatic t_point make_point(input t_coord x, input t_coord y, input t_coord z,
                                          input logic last);
        t_point pt;
        pt.p[0] = x;
        pt.p[1] = y;
        pt.p[2] = z;
        pt.last = last;
        return pt;
    endfunction

    function automatic t_vec pack3(input t_slot x, input t_slot y, input t_slot z);
        return {z, y, x};
    endfunction

    // Coordinates: mostly near the origin so that points fall on both sides of the plane.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0, 1: return t_coord'(int'($urandom_range(0, 2097152)) - 1048576);
            2: return t_coord'(int'($urandom_range(0, 33554432)) - 16777216);
            3: begin
                case ($urandom_range(0, 4))
                    0: return COORD_TOP;
                    1: return COORD_BOTTOM;
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_slot rand_slot();
        case ($urandom_range(0, 5))
            0: return SLOT_ONE;
            1: return -SLOT_ONE;
            2: return '0;
            3: return SLOT_HI;
            4: return SLOT_LO;
            default: return t_slot'($urandom);
        endcase
    endfunction

    // Vectors: unit axes, bounded components, raw bits and extreme components.
    function automatic t_vec rand_vec();
        t_slot c [3];
        t_vec  raw;
        int    i;
        case ($urandom_range(0, 3))
            0: begin
                c = '{'0, '0, '0};
                c[$urandom_range(0, 2)] = $urandom_range(0, 1) ? SLOT_ONE : -SLOT_ONE;
            end
            1: begin
                for (i = 0; i < 3; i++) begin
                    c[i] = t_slot'(int'($urandom_range(0, 1048576)) - 524288);
                end
            end
            2: begin
                raw = t_vec'({$urandom, $urandom});
                return raw;
            end
            default: begin
                for (i = 0; i < 3; i++) begin
                    c[i] = rand_slot();
                end
            end
        endcase
        return pack3(c[0], c[1], c[2]);
    endfunction

    function automatic t_coord rand_offset();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return t_coord'(int'($urandom_range(0, 2097152)) - 1048576);
            2: return t_coord'($urandom);
            default: return t_coord'(int'($urandom_range(0, 8388608)) - 4194304);
        endcase
    endfunction

    // Lowers push and waits until every expected beat has been taken.
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_vec data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_NORMAL_UNIT:  plane_normal = data;
            CFG_PLANE_OFFSET: plane_const = data[COORD_W-1:0];
            CFG_BASIS_FIRST:  basis_u = data;
            default:          basis_v = data;
        endcase
    endtask

    task automatic program_plane(input t_vec nrm, input t_coord d, input t_vec b1,
                                 input t_vec b2);
        wait_idle();
        write_reg(CFG_NORMAL_UNIT, nrm);
        write_reg(CFG_PLANE_OFFSET, {{(VEC_W - COORD_W){1'b0}}, d});
        write_reg(CFG_BASIS_FIRST, b1);
        write_reg(CFG_BASIS_SECOND, b2);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one point, in bursts with random gaps, and records its expected beat.
    task automatic send_point(input t_point pt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        push         <= 1'b1;
        i_point_x    <= pt.p[0];
        i_point_y    <= pt.p[1];
        i_point_z    <= pt.p[2];
        i_point_last <= pt.last;
        do @(posedge i_clk); while (full);
        pending_results = {pending_results, project_point(pt)};
    endtask

    // Receiver: switches between random pop patterns, or holds off on request.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        drain_tick++;
        if (drain_tick % 64 == 0) begin
            drain_mode = t_drain'($urandom_range(0, 3));
        end
        if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (drain_mode)
                DRAIN_ALWAYS: pop <= 1'b1;
                DRAIN_HALF:   pop <= 1'($urandom_range(0, 1));
                DRAIN_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
                default:      pop <= (drain_tick % 5 < 3);
            endcase
        end
    end

    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Each popped beat is compared field by field with the oldest expected beat.
    always @(posedge i_clk) begin : check_beat
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected beat, expected none, got u=%h v=%h",
                         $time, o_plane_u, o_plane_v);
            end else begin
                want = pending_results.pop_front();
                note_field("plane_u", 64'(want.u), 64'(o_plane_u));
                note_field("plane_v", 64'(want.v), 64'(o_plane_v));
                note_field("set_done", 64'(want.last), 64'(o_set_done));
                note_field("offset_x", 64'(want.ox), 64'(o_offset_x));
                note_field("offset_y", 64'(want.oy), 64'(o_offset_y));
                note_field("offset_z", 64'(want.oz), 64'(o_offset_z));
                note_field("thickness", 64'(want.thick), 64'(o_thickness));
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // With every register still at reset the distance is zero and nothing is offset.
    task automatic test_reset_state();
        send_point(make_point(COORD_TOP, COORD_BOTTOM, 32'sh1234_5678, 1'b0));
        send_point(make_point(-ONE_Q16, 3 * ONE_Q16, COORD_BOTTOM, 1'b1));
    endtask

    // Axis plane: nearest above, switch to below, ignored later points, point on plane.
    task automatic test_plane_geometry();
        program_plane(pack3(SLOT_ONE, '0, '0), '0, pack3('0, SLOT_ONE, '0),
                      pack3('0, '0, SLOT_ONE));
        send_point(make_point(5 * ONE_Q16, 3 * ONE_Q16 / 2, -2 * ONE_Q16, 1'b0));
        send_point(make_point(2 * ONE_Q16, ONE_Q16, ONE_Q16, 1'b0));
        send_point(make_point('0, -ONE_Q16, 7 * ONE_Q16, 1'b0));
        send_point(make_point(-3 * ONE_Q16, ONE_Q16 / 2, '0, 1'b0));
        send_point(make_point(ONE_Q16 / 2, 4 * ONE_Q16, -ONE_Q16, 1'b0));
        send_point(make_point(-ONE_Q16, '0, 2 * ONE_Q16, 1'b0));
        send_point(make_point(7 * ONE_Q16, -5 * ONE_Q16, 9 * ONE_Q16, 1'b1));

        // Tilted plane with a negative constant.
        program_plane(pack3(21'sd314573, 21'sd419430, '0), -5 * ONE_Q16 / 4,
                      pack3(21'sd419430, -21'sd314573, '0), pack3('0, '0, SLOT_ONE));
        send_point(make_point(3 * ONE_Q16, 2 * ONE_Q16, ONE_Q16, 1'b0));
        send_point(make_point(-ONE_Q16, ONE_Q16 / 4, -6 * ONE_Q16, 1'b0));
        send_point(make_point(ONE_Q16, ONE_Q16, 32'sh0000_0001, 1'b1));
    endtask

    // Extreme registers and points: saturated distances, ties at saturation,
    // saturated kept distance, largest thickness.
    task automatic test_saturation();
        program_plane(pack3(SLOT_HI, SLOT_HI, SLOT_HI), COORD_TOP,
                      pack3(SLOT_HI, SLOT_HI, SLOT_HI), pack3(SLOT_LO, SLOT_LO, SLOT_LO));
        send_point(make_point(COORD_TOP, COORD_TOP, COORD_TOP, 1'b0));
        send_point(make_point(COORD_TOP, COORD_TOP, '0, 1'b0));
        send_point(make_point(COORD_TOP, '0, '0, 1'b1));

        program_plane(pack3(SLOT_LO, SLOT_LO, SLOT_LO), COORD_BOTTOM,
                      pack3(SLOT_LO, SLOT_LO, SLOT_LO), pack3(SLOT_HI, SLOT_HI, SLOT_HI));
        send_point(make_point(COORD_TOP, COORD_TOP, COORD_TOP, 1'b0));
        send_point(make_point('0, COORD_TOP, COORD_TOP, 1'b0));
        send_point(make_point(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b1));
    endtask

    // The normal changes inside a set; the offset follows the normal in use at the end.
    task automatic test_config_mid_set();
        program_plane(pack3(SLOT_ONE, '0, '0), ONE_Q16, pack3('0, SLOT_ONE, '0),
                      pack3('0, '0, -SLOT_ONE));
        send_point(make_point(-4 * ONE_Q16, ONE_Q16, ONE_Q16, 1'b0));
        send_point(make_point(2 * ONE_Q16, -ONE_Q16, 3 * ONE_Q16, 1'b0));
        program_plane(pack3('0, -SLOT_ONE, '0), -ONE_Q16, pack3(SLOT_ONE, '0, '0),
                      pack3('0, '0, SLOT_ONE));
        send_point(make_point(ONE_Q16, 6 * ONE_Q16, -2 * ONE_Q16, 1'b1));
    endtask

    // Random sets of random length; the plane is reprogrammed every hundred points,
    // which also lands inside open sets.
    task automatic test_random_sets(input int n_items);
        int     sent;
        int     set_left;
        t_point pt;
        t_point prev;
        sent = 0;
        set_left = 0;
        prev = make_point('0, '0, '0, 1'b0);
        while (sent < n_items) begin
            if (sent % 100 == 0) begin
                program_plane(rand_vec(), rand_offset(), rand_vec(), rand_vec());
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (set_left == 0) begin
                set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 8);
            end
            // A repeated point makes a tie with the current extreme.
            if ($urandom_range(0, 7) == 0) begin
                pt = prev;
            end else begin
                pt = make_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
            end
            pt.last = (set_left == 1);
            set_left--;
            send_point(pt);
            prev = pt;
            sent++;
        end
    endtask

    // The receiver holds off long enough for both queues to fill and full to rise.
    task automatic test_backpressure();
        int i;
        gaps_on = 1'b0;
        send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 1'b0));
        hold_request = 120;
        for (i = 0; i < 40; i++) begin
            send_point(make_point(rand_coord(), rand_coord(), rand_coord(), i == 39));
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_plane_geometry();
        test_saturation();
        test_config_mid_set();
        test_random_sets(500);
        test_backpressure();
        test_random_sets(500);
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ppet_pkg.sv
src/ppet_front.sv
src/ppet_queue.sv
src/ppet_back.sv
src/plane_projection_extent_tracker.sv
bench/tb_top.sv
